// ===== design/rhr_pkg.sv =====
// Shared constants and types for the plane mirror ray hit and reflect unit.
`timescale 1ns / 1ps
package rhr_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int TOL_WIDTH       = 16;
	localparam int CFG_IDX_W       = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EDGE_A_X   = 3'd0,
		CFG_EDGE_A_Y   = 3'd1,
		CFG_EDGE_B_X   = 3'd2,
		CFG_EDGE_B_Y   = 3'd3,
		CFG_ZERO_TOL   = 3'd4
	} cfg_idx_t;

	// Per-item decisions that ride alongside the divider chains
	typedef struct packed {
		logic hit;
		logic parallel;
		logic pneg;
		logic refl;
		logic degen;
		logic xneg;
		logic yneg;
	} flags_t;

endpackage

// ===== design/rhr_in_if.sv =====
// Ray input channel: valid/ready handshake with one ray segment per item.
`timescale 1ns / 1ps
interface rhr_in_if #(parameter int COORD_WIDTH = rhr_pkg::COORD_WIDTH_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;

	modport source(output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== design/rhr_out_if.sv =====
// Result channel: valid/ready handshake with hit and reflection results per item.
`timescale 1ns / 1ps
interface rhr_out_if #(parameter int COORD_WIDTH = rhr_pkg::COORD_WIDTH_DEF);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [COORD_WIDTH-1:0] hit_param;
	logic                          parallel;
	logic                          reflected;
	logic signed [COORD_WIDTH-1:0] refl_x;
	logic signed [COORD_WIDTH-1:0] refl_y;
	logic                          degenerate;

	modport source(output valid, hit, hit_param, parallel, reflected, refl_x, refl_y,
		degenerate, input ready);
	modport sink(input valid, hit, hit_param, parallel, reflected, refl_x, refl_y,
		degenerate, output ready);
endinterface

// ===== design/plane_mirror_ray_hit_reflect_unit.sv =====
// Top level: ray/mirror hit test and reflection, fully pipelined.
//
// Usage:
//  - ray (sink) takes one ray segment per item: start and end point, signed fixed point.
//  - res (source) gives one result per item: hit, hit_param, parallel, reflected,
//    refl_x, refl_y and degenerate.
//  - The mirror edges and zero tolerance are written through cfg_we/cfg_idx/cfg_data;
//    write them only while no item is in flight.
//  - One item enters per cycle while res is not stalled. From acceptance to res.valid
//    an item passes through six arithmetic stages,
//    a divider overflow stage, one divider cell per quotient bit
//    (COORD_WIDTH + 3 cells) and the output register, the first stage loading
//    at the accepting edge.
//  - Three divider chains of identical length run side by side: hit parameter,
//    reflected x and reflected y.
//  - When res.ready is low with a result held, the whole pipeline holds and
//    ray.ready drops; it resumes the cycle the result is taken.
//  - Reset empties the pipeline and loads the default mirror from (0,-1) to (0,1)
//    with a tolerance of one LSB.
`timescale 1ns / 1ps
module plane_mirror_ray_hit_reflect_unit #(
	parameter int COORD_WIDTH = rhr_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rhr_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rhr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [COORD_WIDTH-1:0]         cfg_data,
	rhr_in_if.sink                         ray,
	rhr_out_if.source                      res
);
	import rhr_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int D    = W + 1;
	localparam int P    = 2 * D;
	localparam int X    = P + 1;
	localparam int TOLW = TOL_WIDTH + F;
	localparam int CW   = (X > TOLW + 1) ? X : TOLW + 1;
	localparam int H    = (X + 1) / 2;
	localparam int HIW  = X - H;
	localparam int LOW  = D + H + 1;
	localparam int PHW  = D + HIW;
	localparam int RW   = D + X;
	localparam int ND1  = X + F;
	localparam int ND2  = RW + 1;
	localparam int Q    = W + 3;
	localparam int SW   = W + 2;
	localparam int FW   = W + 5;
	localparam int NV   = 6 + Q + 1;

	localparam logic [W-1:0] C_MAX       = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] C_MIN       = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] C_MINUS_ONE = {{(W-F){1'b1}}, {F{1'b0}}};
	localparam logic [W-1:0] C_PLUS_ONE  = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic [Q-1:0] Q_POS_LIM   = {{(Q-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [Q-1:0] Q_NEG_LIM   = {{(Q-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

	// configuration registers
	logic signed [W-1:0]         ax_q, ay_q, bx_q, by_q;
	logic [TOL_WIDTH-1:0]        tol_q;

	logic signed [D-1:0]         mdx, nx, ny;
	logic signed [CW-1:0]        tol_c, ntol_c;

	logic                        en;
	logic [NV-1:0]               v_q;

	// stage 1
	logic signed [D-1:0]  rdx_s1, rdy_s1, asx_s1, asy_s1, bsx_s1, bsy_s1, sex_s1, sey_s1;
	logic signed [SW-1:0] e2x_s1, e2y_s1;
	// stage 2
	logic signed [P-1:0]  pl1_s2, pl2_s2, pr1_s2, pr2_s2, pn1_s2, pn2_s2, pd1_s2, pd2_s2;
	logic signed [P-1:0]  pm1_s2, pm2_s2, pq1_s2, pq2_s2;
	logic signed [SW-1:0] e2x_s2, e2y_s2;
	// stage 3
	logic signed [X-1:0]  l_s3, r_s3, num_s3, den_s3, num2_s3, den2_s3;
	logic signed [SW-1:0] e2x_s3, e2y_s3;
	// stage 4
	logic signed [LOW-1:0] plx_s4, ply_s4;
	logic signed [PHW-1:0] phx_s4, phy_s4;
	logic [ND1-1:0]        dvd1_s4;
	logic [X-1:0]          dv1_s4, den2_s4;
	flags_t                fl_s4;
	logic signed [SW-1:0]  e2x_s4, e2y_s4;
	// stage 5
	logic signed [RW-1:0]  prx_s5, pry_s5;
	logic [ND1-1:0]        dvd1_s5;
	logic [X-1:0]          dv1_s5, den2_s5;
	flags_t                fl_s5;
	logic signed [SW-1:0]  e2x_s5, e2y_s5;
	// stage 6
	logic [ND2-1:0]        dvdx_s6, dvdy_s6;
	logic [ND1-1:0]        dvd1_s6;
	logic [X-1:0]          dv1_s6, den2_s6;
	flags_t                fl_s6;
	logic signed [SW-1:0]  e2x_s6, e2y_s6;

	// sideband delay line along the divider chains
	flags_t                fl_d  [Q+1];
	logic signed [SW-1:0]  e2x_d [Q+1];
	logic signed [SW-1:0]  e2y_d [Q+1];

	logic signed [H:0]     l_lo_x;
	logic [H-1:0]          n2_lo;
	logic signed [HIW-1:0] n2_hi;
	logic signed [CW-1:0]  l_e, r_e, n2_e;
	logic                  same;

	logic [Q-1:0]          q1, qx, qy;
	logic                  ovf1, ovfx, ovfy;
	flags_t                fl_f;
	logic [W-1:0]          param_n;
	logic signed [Q:0]     qsx, qsy;
	logic signed [FW-1:0]  sumx, sumy;
	logic [W-1:0]          rx_n, ry_n;

	assign en        = !res.valid || res.ready;
	assign ray.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q  <= '0;
			ay_q  <= C_MINUS_ONE;
			bx_q  <= '0;
			by_q  <= C_PLUS_ONE;
			tol_q <= TOL_WIDTH'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_EDGE_A_X: ax_q  <= cfg_data;
				CFG_EDGE_A_Y: ay_q  <= cfg_data;
				CFG_EDGE_B_X: bx_q  <= cfg_data;
				CFG_EDGE_B_Y: by_q  <= cfg_data;
				CFG_ZERO_TOL: tol_q <= cfg_data[TOL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign mdx    = D'(bx_q) - D'(ax_q);
	assign nx     = D'(by_q) - D'(ay_q);
	assign ny     = D'(ax_q) - D'(bx_q);
	assign tol_c  = CW'({tol_q, {F{1'b0}}});
	assign ntol_c = -tol_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NV-2:0], ray.valid};
		end
	end

	// stage 4 decisions; side = -num2, so the front side is num2 > tol
	assign l_e  = CW'(l_s3);
	assign r_e  = CW'(r_s3);
	assign n2_e = CW'(num2_s3);
	assign same = ((l_e > tol_c) && (r_e > tol_c)) || ((l_e < ntol_c) && (r_e < ntol_c));
	assign n2_lo = num2_s3[H-1:0];
	assign n2_hi = num2_s3[X-1:H];
	assign l_lo_x = $signed({1'b0, n2_lo});

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: differences
			rdx_s1 <= D'(ray.end_x) - D'(ray.start_x);
			rdy_s1 <= D'(ray.end_y) - D'(ray.start_y);
			asx_s1 <= D'(ax_q) - D'(ray.start_x);
			asy_s1 <= D'(ay_q) - D'(ray.start_y);
			bsx_s1 <= D'(bx_q) - D'(ray.start_x);
			bsy_s1 <= D'(by_q) - D'(ray.start_y);
			sex_s1 <= D'(ray.start_x) - D'(ray.end_x);
			sey_s1 <= D'(ray.start_y) - D'(ray.end_y);
			e2x_s1 <= (SW'(ray.end_x) <<< 1) - SW'(ray.start_x);
			e2y_s1 <= (SW'(ray.end_y) <<< 1) - SW'(ray.start_y);

			// stage 2: products
			pl1_s2 <= rdy_s1 * asx_s1;
			pl2_s2 <= rdx_s1 * asy_s1;
			pr1_s2 <= rdy_s1 * bsx_s1;
			pr2_s2 <= rdx_s1 * bsy_s1;
			pn1_s2 <= nx * asx_s1;
			pn2_s2 <= mdx * asy_s1;
			pd1_s2 <= nx * rdx_s1;
			pd2_s2 <= mdx * rdy_s1;
			pm1_s2 <= nx * sex_s1;
			pm2_s2 <= ny * sey_s1;
			pq1_s2 <= nx * nx;
			pq2_s2 <= ny * ny;
			e2x_s2 <= e2x_s1;
			e2y_s2 <= e2y_s1;

			// stage 3: cross products
			l_s3    <= X'(pl1_s2) - X'(pl2_s2);
			r_s3    <= X'(pr1_s2) - X'(pr2_s2);
			num_s3  <= X'(pn1_s2) - X'(pn2_s2);
			den_s3  <= X'(pd1_s2) - X'(pd2_s2);
			num2_s3 <= X'(pm1_s2) + X'(pm2_s2);
			den2_s3 <= X'(pq1_s2) + X'(pq2_s2);
			e2x_s3  <= e2x_s2;
			e2y_s3  <= e2y_s2;

			// stage 4: decisions, magnitudes for the hit divider, partial products
			fl_s4.hit      <= !same;
			fl_s4.parallel <= !same && (den_s3 == '0);
			fl_s4.pneg     <= (den_s3 == '0) ? num_s3[X-1] : (num_s3[X-1] ^ den_s3[X-1]);
			fl_s4.degen    <= (den2_s3 == '0);
			fl_s4.refl     <= (den2_s3 != '0) && (n2_e > tol_c);
			fl_s4.xneg     <= 1'b0;
			fl_s4.yneg     <= 1'b0;
			dvd1_s4 <= {(num_s3[X-1] ? X'(-num_s3) : X'(num_s3)), {F{1'b0}}};
			dv1_s4  <= den_s3[X-1] ? X'(-den_s3) : X'(den_s3);
			den2_s4 <= den2_s3;
			plx_s4  <= nx * l_lo_x;
			ply_s4  <= ny * l_lo_x;
			phx_s4  <= nx * n2_hi;
			phy_s4  <= ny * n2_hi;
			e2x_s4  <= e2x_s3;
			e2y_s4  <= e2y_s3;

			// stage 5: join partial products
			prx_s5  <= (RW'(phx_s4) <<< H) + RW'(plx_s4);
			pry_s5  <= (RW'(phy_s4) <<< H) + RW'(ply_s4);
			dvd1_s5 <= dvd1_s4;
			dv1_s5  <= dv1_s4;
			den2_s5 <= den2_s4;
			fl_s5   <= fl_s4;
			e2x_s5  <= e2x_s4;
			e2y_s5  <= e2y_s4;

			// stage 6: doubled magnitudes for the reflection dividers
			dvdx_s6 <= {(prx_s5[RW-1] ? RW'(-prx_s5) : RW'(prx_s5)), 1'b0};
			dvdy_s6 <= {(pry_s5[RW-1] ? RW'(-pry_s5) : RW'(pry_s5)), 1'b0};
			dvd1_s6 <= dvd1_s5;
			dv1_s6  <= dv1_s5;
			den2_s6 <= den2_s5;
			fl_s6   <= '{hit: fl_s5.hit, parallel: fl_s5.parallel, pneg: fl_s5.pneg,
				refl: fl_s5.refl, degen: fl_s5.degen, xneg: prx_s5[RW-1],
				yneg: pry_s5[RW-1]};
			e2x_s6  <= e2x_s5;
			e2y_s6  <= e2y_s5;

			fl_d[0]  <= fl_s6;
			e2x_d[0] <= e2x_s6;
			e2y_d[0] <= e2y_s6;
		end
	end

	for (genvar i = 0; i < Q; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				fl_d[i+1]  <= fl_d[i];
				e2x_d[i+1] <= e2x_d[i];
				e2y_d[i+1] <= e2y_d[i];
			end
		end
	end

	rhr_div_chain #(.ND(ND1), .DV(X), .Q(Q)) u_div_hit (
		.clk (clk), .en (en), .dvd (dvd1_s6), .dv (dv1_s6), .quo (q1), .ovf (ovf1)
	);
	rhr_div_chain #(.ND(ND2), .DV(X), .Q(Q)) u_div_rx (
		.clk (clk), .en (en), .dvd (dvdx_s6), .dv (den2_s6), .quo (qx), .ovf (ovfx)
	);
	rhr_div_chain #(.ND(ND2), .DV(X), .Q(Q)) u_div_ry (
		.clk (clk), .en (en), .dvd (dvdy_s6), .dv (den2_s6), .quo (qy), .ovf (ovfy)
	);

	assign fl_f = fl_d[Q];

	// hit parameter: sign, saturation and the special cases
	always_comb begin
		if (!fl_f.hit) begin
			param_n = C_MINUS_ONE;
		end else if (fl_f.parallel || ovf1) begin
			param_n = fl_f.pneg ? C_MIN : C_MAX;
		end else if (!fl_f.pneg) begin
			param_n = (q1 > Q_POS_LIM) ? C_MAX : q1[W-1:0];
		end else begin
			param_n = (q1 > Q_NEG_LIM) ? C_MIN : W'(W'(0) - q1[W-1:0]);
		end
	end

	// reflection: 2E - S + q, where the quotient is bounded by twice the segment length
	assign qsx  = fl_f.xneg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign qsy  = fl_f.yneg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
	assign sumx = FW'(e2x_d[Q]) + FW'(qsx);
	assign sumy = FW'(e2y_d[Q]) + FW'(qsy);

	always_comb begin
		if (!fl_f.refl || ovfx) begin
			rx_n = '0;
		end else if (sumx > FW'($signed(C_MAX))) begin
			rx_n = C_MAX;
		end else if (sumx < FW'($signed(C_MIN))) begin
			rx_n = C_MIN;
		end else begin
			rx_n = sumx[W-1:0];
		end
		if (!fl_f.refl || ovfy) begin
			ry_n = '0;
		end else if (sumy > FW'($signed(C_MAX))) begin
			ry_n = C_MAX;
		end else if (sumy < FW'($signed(C_MIN))) begin
			ry_n = C_MIN;
		end else begin
			ry_n = sumy[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (en) begin
			res.valid <= v_q[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.hit        <= fl_f.hit;
			res.hit_param  <= param_n;
			res.parallel   <= fl_f.parallel;
			res.reflected  <= fl_f.refl;
			res.refl_x     <= rx_n;
			res.refl_y     <= ry_n;
			res.degenerate <= fl_f.degen;
		end
	end
endmodule

// ===== design/rhr_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per stage.
`timescale 1ns / 1ps
module rhr_div_cell #(
	parameter int DV = 67,
	parameter int Q  = 35
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DV-1:0] rem_i,
	input  logic [Q-1:0]  low_i,
	input  logic [Q-1:0]  quo_i,
	input  logic [DV-1:0] dv_i,
	input  logic          ovf_i,
	output logic [DV-1:0] rem_o,
	output logic [Q-1:0]  low_o,
	output logic [Q-1:0]  quo_o,
	output logic [DV-1:0] dv_o,
	output logic          ovf_o
);
	logic [DV:0]   r2;
	logic [DV+1:0] diff;
	logic          ge;

	assign r2   = {rem_i, low_i[Q-1]};
	assign diff = {1'b0, r2} - {2'b00, dv_i};
	assign ge   = !diff[DV+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[DV-1:0] : r2[DV-1:0];
			low_o <= {low_i[Q-2:0], 1'b0};
			quo_o <= {quo_i[Q-2:0], ge};
			dv_o  <= dv_i;
			ovf_o <= ovf_i;
		end
	end
endmodule

// ===== design/rhr_div_chain.sv =====
// Pipelined unsigned divider: an overflow check stage, then one cell per quotient bit.
`timescale 1ns / 1ps
module rhr_div_chain #(
	parameter int ND = 83,
	parameter int DV = 67,
	parameter int Q  = 35
) (
	input  logic          clk,
	input  logic          en,
	input  logic [ND-1:0] dvd,
	input  logic [DV-1:0] dv,
	output logic [Q-1:0]  quo,
	output logic          ovf
);
	localparam int TW = ND - Q;
	localparam int MW = (TW > DV) ? TW : DV;

	logic [MW-1:0] top_ext;
	logic [MW-1:0] dv_ext;

	logic [DV-1:0] rem_c [Q+1];
	logic [Q-1:0]  low_c [Q+1];
	logic [Q-1:0]  quo_c [Q+1];
	logic [DV-1:0] dv_c  [Q+1];
	logic          ovf_c [Q+1];

	assign top_ext = MW'(dvd[ND-1:Q]);
	assign dv_ext  = MW'(dv);

	// Quotient needs more than Q bits exactly when the upper dividend part reaches the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_c[0] <= DV'(top_ext);
			low_c[0] <= dvd[Q-1:0];
			quo_c[0] <= '0;
			dv_c[0]  <= dv;
			ovf_c[0] <= (top_ext >= dv_ext);
		end
	end

	for (genvar i = 0; i < Q; i++) begin : g_cell
		rhr_div_cell #(.DV(DV), .Q(Q)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (rem_c[i]),
			.low_i (low_c[i]),
			.quo_i (quo_c[i]),
			.dv_i  (dv_c[i]),
			.ovf_i (ovf_c[i]),
			.rem_o (rem_c[i+1]),
			.low_o (low_c[i+1]),
			.quo_o (quo_c[i+1]),
			.dv_o  (dv_c[i+1]),
			.ovf_o (ovf_c[i+1])
		);
	end

	assign quo = quo_c[Q];
	assign ovf = ovf_c[Q];
endmodule

// ===== design/rhr_checker.sv =====
// Port-level checks for the ray hit and reflect unit, bound to the top level.
`timescale 1ns / 1ps
module rhr_checker #(
	parameter int COORD_WIDTH = rhr_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rhr_pkg::FRAC_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic                   res_hit,
	input logic [COORD_WIDTH-1:0] res_hit_param,
	input logic                   res_parallel,
	input logic                   res_reflected,
	input logic [COORD_WIDTH-1:0] res_refl_x,
	input logic [COORD_WIDTH-1:0] res_refl_y,
	input logic                   res_degenerate
);
	localparam logic [COORD_WIDTH-1:0] MINUS_ONE =
		{{(COORD_WIDTH-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_hit_param))
		else $error("result dropped or changed while stalled");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_hit |-> res_hit_param == MINUS_ONE && !res_parallel)
		else $error("miss without minus one parameter");

	a_par: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_parallel |-> res_hit)
		else $error("parallel flagged without hit");

	a_norefl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_reflected |-> res_refl_x == '0 && res_refl_y == '0)
		else $error("reflected point nonzero without reflection");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_degenerate |-> !res_reflected)
		else $error("reflection on degenerate mirror");
endmodule

bind plane_mirror_ray_hit_reflect_unit rhr_checker #(
	.COORD_WIDTH (COORD_WIDTH),
	.FRAC_BITS   (FRAC_BITS)
) u_rhr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_hit        (res.hit),
	.res_hit_param  (res.hit_param),
	.res_parallel   (res.parallel),
	.res_reflected  (res.reflected),
	.res_refl_x     (res.refl_x),
	.res_refl_y     (res.refl_y),
	.res_degenerate (res.degenerate)
);
